/* rtl/assert_macros.svh */
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define APR_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: name");

// Invariant checked on every clock edge outside reset.
`define APR_ASSERT_ALW(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed: name");

`else

`define APR_ASSERT_IMP(name, clk, rstn, ante, cons)
`define APR_ASSERT_ALW(name, clk, rstn, cond)

`endif

`endif

/* rtl/apr_pkg.sv */
package apr_pkg;

    // Default sizes
    localparam int FRAMES_DEF    = 16;
    localparam int AGE_BITS_DEF  = 8;
    localparam int PAGE_BITS_DEF = 16;

    // Fixed field widths
    localparam int CFG_BITS   = 5;
    localparam int FIDX_BITS  = 4;
    localparam int TOTAL_BITS = 32;

    // Reset value of frames_in_use
    localparam logic [CFG_BITS-1:0] FRAMES_IN_USE_RST = 5'd16;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_COMMIT
    } apr_state_t;

    // Search flags carried along the cell row
    typedef struct packed {
        logic hit_found;
        logic empty_found;
        logic have_best;
    } apr_flags_t;

    // Update command broadcast to all cells
    typedef struct packed {
        logic en;
        logic hit;
    } apr_cmd_t;

endpackage

/* rtl/aging_page_replacement.sv */
// Aging page replacement (8-bit LRU approximation), one frame per cell.
//
// Input channel in_valid/in_ready carries page_number; one transaction is
// one page reference. Output channel out_valid/out_ready returns one result
// per reference: hit, frame_index, evicted_valid, evicted_page and the
// saturating fault_total/hit_total after that reference.
// cfg_we/cfg_wdata writes frames_in_use (0 acts as 1, above FRAMES acts as
// FRAMES); write it only while no reference is in flight.
//
// On acceptance a search token walks the row of frame cells one cell per
// cycle, then a commit step ages the active frames and updates the chosen
// one. One reference is in flight at a time and the next is taken the
// cycle after commit, so a new reference is not accepted before the last
// one has committed.
// A finished result sits in the output register; the next reference is
// accepted while it waits. If the receiver stalls, the following commit
// holds until the output register frees up.
// Reset empties all frames, clears ages and totals, and sets
// frames_in_use to 16.
module aging_page_replacement #(
    parameter int FRAMES    = apr_pkg::FRAMES_DEF,
    parameter int AGE_BITS  = apr_pkg::AGE_BITS_DEF,
    parameter int PAGE_BITS = apr_pkg::PAGE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [apr_pkg::CFG_BITS-1:0]    cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [PAGE_BITS-1:0]            page_number,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit,
    output logic [apr_pkg::FIDX_BITS-1:0]   frame_index,
    output logic                            evicted_valid,
    output logic [PAGE_BITS-1:0]            evicted_page,
    output logic [apr_pkg::TOTAL_BITS-1:0]  fault_total,
    output logic [apr_pkg::TOTAL_BITS-1:0]  hit_total
);
    import apr_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    apr_state_t            state_reg, state_next;
    logic [CFG_BITS-1:0]   fiu_reg;
    logic [CNT_W-1:0]      n_active;
    logic [PAGE_BITS-1:0]  page_reg;
    logic                  start_reg;
    logic                  accept;
    logic                  commit;
    apr_cmd_t              cmd;
    logic [IDX_W-1:0]      cmd_pos;

    // Output register
    logic                  out_valid_reg;
    logic                  hit_reg;
    logic [FIDX_BITS-1:0]  fidx_reg;
    logic                  ev_valid_reg;
    logic [PAGE_BITS-1:0]  ev_page_reg;
    logic [TOTAL_BITS-1:0] fault_reg, fault_next;
    logic [TOTAL_BITS-1:0] hitcnt_reg, hitcnt_next;

    // Chain wiring, entry FRAMES is the row output
    logic                  tok   [FRAMES+1];
    apr_flags_t            flags [FRAMES+1];
    logic [IDX_W-1:0]      hidx  [FRAMES+1];
    logic [IDX_W-1:0]      eidx  [FRAMES+1];
    logic [AGE_BITS-1:0]   bage  [FRAMES+1];
    logic [IDX_W-1:0]      bidx  [FRAMES+1];
    logic [PAGE_BITS-1:0]  bpage [FRAMES+1];
    logic [FRAMES-1:0]     tok_vec;

    // Active frame count, clamped to 1..FRAMES
    always_comb
    begin
        if (fiu_reg == '0)
        begin
            n_active = CNT_W'(1);
        end
        else if (32'(fiu_reg) > 32'(FRAMES))
        begin
            n_active = CNT_W'(FRAMES);
        end
        else
        begin
            n_active = CNT_W'(fiu_reg);
        end
    end

    // Head of the chain
    assign tok[0]   = start_reg;
    assign flags[0] = '0;
    assign hidx[0]  = '0;
    assign eidx[0]  = '0;
    assign bage[0]  = '0;
    assign bidx[0]  = '0;
    assign bpage[0] = '0;

    // Row of frame cells
    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        logic act;
        assign act        = (n_active > CNT_W'(i));
        assign tok_vec[i] = tok[i+1];

        apr_cell #(
            .INDEX     (i),
            .IDX_W     (IDX_W),
            .AGE_BITS  (AGE_BITS),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .active        (act),
            .page          (page_reg),
            .tok_in        (tok[i]),
            .tok_out       (tok[i+1]),
            .flags_in      (flags[i]),
            .flags_out     (flags[i+1]),
            .hit_idx_in    (hidx[i]),
            .hit_idx_out   (hidx[i+1]),
            .empty_idx_in  (eidx[i]),
            .empty_idx_out (eidx[i+1]),
            .best_age_in   (bage[i]),
            .best_age_out  (bage[i+1]),
            .best_idx_in   (bidx[i]),
            .best_idx_out  (bidx[i+1]),
            .best_page_in  (bpage[i]),
            .best_page_out (bpage[i+1]),
            .cmd           (cmd),
            .cmd_pos       (cmd_pos)
        );
    end

    // Sequencer: next state and commit decision
    always_comb
    begin
        state_next  = state_reg;
        accept      = 1'b0;
        commit      = 1'b0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    accept     = 1'b1;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (tok[FRAMES])
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Choose the frame: hit, else first empty, else oldest
    always_comb
    begin
        cmd.en  = commit;
        cmd.hit = flags[FRAMES].hit_found;
        if (flags[FRAMES].hit_found)
        begin
            cmd_pos = hidx[FRAMES];
        end
        else if (flags[FRAMES].empty_found)
        begin
            cmd_pos = eidx[FRAMES];
        end
        else
        begin
            cmd_pos = bidx[FRAMES];
        end
    end

    // Saturating totals
    always_comb
    begin
        fault_next  = fault_reg;
        hitcnt_next = hitcnt_reg;
        if (flags[FRAMES].hit_found)
        begin
            if (hitcnt_reg != TOTAL_MAX)
            begin
                hitcnt_next = hitcnt_reg + 1'b1;
            end
        end
        else if (fault_reg != TOTAL_MAX)
        begin
            fault_next = fault_reg + 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fiu_reg       <= FRAMES_IN_USE_RST;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            fault_reg     <= '0;
            hitcnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (cfg_we)
            begin
                fiu_reg <= cfg_wdata;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                fault_reg     <= fault_next;
                hitcnt_reg    <= hitcnt_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= page_number;
        end
        if (commit)
        begin
            hit_reg      <= flags[FRAMES].hit_found;
            fidx_reg     <= FIDX_BITS'(cmd_pos);
            ev_valid_reg <= !flags[FRAMES].hit_found && !flags[FRAMES].empty_found;
            if (!flags[FRAMES].hit_found && !flags[FRAMES].empty_found)
            begin
                ev_page_reg <= bpage[FRAMES];
            end
            else
            begin
                ev_page_reg <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = fidx_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_total   = fault_reg;
    assign hit_total     = hitcnt_reg;

    // At most one search token in the row
    `APR_ASSERT_ALW(a_one_token, clk, rst_n, $onehot0({tok_vec, start_reg}))
    // Token only travels while a search is running
    `APR_ASSERT_IMP(a_tok_sweep, clk, rst_n, (tok_vec != '0) || start_reg, state_reg == ST_SWEEP)
    // A hit never reports an eviction
    `APR_ASSERT_IMP(a_hit_no_evict, clk, rst_n, out_valid_reg && hit_reg, !ev_valid_reg)
    // Commit only follows a completed search
    `APR_ASSERT_IMP(a_commit_order, clk, rst_n, commit,
        $past(state_reg) == ST_SWEEP || $past(state_reg) == ST_COMMIT)

endmodule

/* rtl/apr_cell.sv */
module apr_cell #(
    parameter int INDEX     = 0,
    parameter int IDX_W     = 4,
    parameter int AGE_BITS  = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     active,
    input  logic [PAGE_BITS-1:0]     page,
    // search chain, one cell per cycle
    input  logic                     tok_in,
    output logic                     tok_out,
    input  apr_pkg::apr_flags_t      flags_in,
    output apr_pkg::apr_flags_t      flags_out,
    input  logic [IDX_W-1:0]         hit_idx_in,
    output logic [IDX_W-1:0]         hit_idx_out,
    input  logic [IDX_W-1:0]         empty_idx_in,
    output logic [IDX_W-1:0]         empty_idx_out,
    input  logic [AGE_BITS-1:0]      best_age_in,
    output logic [AGE_BITS-1:0]      best_age_out,
    input  logic [IDX_W-1:0]         best_idx_in,
    output logic [IDX_W-1:0]         best_idx_out,
    input  logic [PAGE_BITS-1:0]     best_page_in,
    output logic [PAGE_BITS-1:0]     best_page_out,
    // update command
    input  apr_pkg::apr_cmd_t        cmd,
    input  logic [IDX_W-1:0]         cmd_pos
);
    import apr_pkg::*;

    localparam logic [IDX_W-1:0]    MY_IDX  = IDX_W'(INDEX);
    localparam logic [AGE_BITS-1:0] AGE_MSB = {1'b1, {(AGE_BITS-1){1'b0}}};

    logic                 valid_reg, valid_next;
    logic [AGE_BITS-1:0]  age_reg, age_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 tok_reg;
    apr_flags_t           flags_reg, flags_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]     empty_idx_reg, empty_idx_next;
    logic [AGE_BITS-1:0]  best_age_reg, best_age_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [PAGE_BITS-1:0] best_page_reg, best_page_next;
    logic [AGE_BITS-1:0]  aged;
    logic                 chosen;

    assign aged   = age_reg >> 1;
    assign chosen = (cmd_pos == MY_IDX);

    // Search step: fold this frame into the running result
    always_comb
    begin
        flags_next     = flags_in;
        hit_idx_next   = hit_idx_in;
        empty_idx_next = empty_idx_in;
        best_age_next  = best_age_in;
        best_idx_next  = best_idx_in;
        best_page_next = best_page_in;
        if (active)
        begin
            if (valid_reg && (page_reg == page) && !flags_in.hit_found)
            begin
                flags_next.hit_found = 1'b1;
                hit_idx_next         = MY_IDX;
            end
            if (!valid_reg && !flags_in.empty_found)
            begin
                flags_next.empty_found = 1'b1;
                empty_idx_next         = MY_IDX;
            end
            // strict less keeps the lowest index on ties
            if (!flags_in.have_best || (aged < best_age_in))
            begin
                flags_next.have_best = 1'b1;
                best_age_next        = aged;
                best_idx_next        = MY_IDX;
                best_page_next       = page_reg;
            end
        end
    end

    // Frame update on commit
    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        page_next  = page_reg;
        if (cmd.en && active)
        begin
            age_next = aged;
            if (chosen)
            begin
                if (cmd.hit)
                begin
                    age_next = aged | AGE_MSB;
                end
                else
                begin
                    valid_next = 1'b1;
                    age_next   = AGE_MSB;
                    page_next  = page;
                end
            end
        end
    end

    // Control and age state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
            tok_reg   <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
            tok_reg   <= tok_in;
            if (tok_in)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
        if (tok_in)
        begin
            hit_idx_reg   <= hit_idx_next;
            empty_idx_reg <= empty_idx_next;
            best_age_reg  <= best_age_next;
            best_idx_reg  <= best_idx_next;
            best_page_reg <= best_page_next;
        end
    end

    assign tok_out       = tok_reg;
    assign flags_out     = flags_reg;
    assign hit_idx_out   = hit_idx_reg;
    assign empty_idx_out = empty_idx_reg;
    assign best_age_out  = best_age_reg;
    assign best_idx_out  = best_idx_reg;
    assign best_page_out = best_page_reg;

endmodule
